// ===== design/ipid_pkg.sv =====
// shared types and constants for the incremental pid motor drive
// no dependencies; imported by every module of the block
package ipid_pkg;

    localparam int GainW  = 16;
    localparam int SpeedW = 16;
    localparam int ErrW   = 18;
    localparam int D1W    = 19;
    localparam int D2W    = 20;
    localparam int ProdW  = 37;
    localparam int SumW   = 40;
    localparam int AccW   = 32;
    localparam int DutyW  = 12;
    localparam int CfgAddrW = 4;
    localparam int CfgDataW = 32;

    localparam logic signed [SpeedW-1:0] SpeedClip  = 16'sd250;
    localparam logic signed [SpeedW-1:0] StallLevel = 16'sd15;
    localparam logic signed [AccW-1:0]   DriveCap   = 32'sd3500;
    localparam logic signed [AccW-1:0]   AccMin     = {1'b1, {(AccW-1){1'b0}}};

    typedef enum logic [1:0] {
        REG_PROP  = 2'd0,
        REG_INTEG = 2'd1,
        REG_DERIV = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [GainW-1:0] prop;
        logic [GainW-1:0] integ;
        logic [GainW-1:0] deriv;
    } gains_t;

    typedef struct packed {
        logic                   valid;
        logic                   stall;
        logic signed [ErrW-1:0] e0;
        logic signed [D1W-1:0]  d1;
        logic signed [D2W-1:0]  d2;
    } err_stage_t;

    typedef struct packed {
        logic                    valid;
        logic                    stall;
        logic signed [ProdW-1:0] p_prop;
        logic signed [ProdW-1:0] p_integ;
        logic signed [ProdW-1:0] p_deriv;
    } prod_stage_t;

endpackage

// ===== design/ipid_cfg.sv =====
// gain registers behind the apb-style configuration port
// depends on ipid_pkg
module ipid_cfg
    import ipid_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [CfgDataW-1:0] pwdata,
    output logic [CfgDataW-1:0] prdata,
    output logic                pready,
    output gains_t              gains
);

    gains_t   gains_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign gains  = gains_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_PROP:  gains_reg.prop  <= pwdata[GainW-1:0];
                REG_INTEG: gains_reg.integ <= pwdata[GainW-1:0];
                REG_DERIV: gains_reg.deriv <= pwdata[GainW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PROP:  prdata = CfgDataW'(gains_reg.prop);
            REG_INTEG: prdata = CfgDataW'(gains_reg.integ);
            REG_DERIV: prdata = CfgDataW'(gains_reg.deriv);
            default:   prdata = '0;
        endcase
    end

endmodule

// ===== design/ipid_err.sv =====
// input register, speed clip, error history and error differences
// depends on ipid_pkg
module ipid_err
    import ipid_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [SpeedW-1:0] target_speed,
    input  logic signed [SpeedW-1:0] measured_speed,
    output err_stage_t               out_stage,
    input  logic                     out_ready
);

    logic                     a_valid_reg;
    logic signed [SpeedW-1:0] a_target_reg;
    logic signed [SpeedW-1:0] a_measured_reg;
    err_stage_t               b_reg;
    logic signed [ErrW-1:0]   hist0_reg;
    logic signed [ErrW-1:0]   hist1_reg;

    logic                     a_ready;
    logic                     b_ready;
    logic signed [SpeedW-1:0] meas_clip;
    logic signed [ErrW-1:0]   e0_next;
    logic signed [D2W-1:0]    e0_x;
    logic signed [D2W-1:0]    h0_x;
    logic signed [D2W-1:0]    h1_x;
    logic signed [D1W-1:0]    d1_next;
    logic signed [D2W-1:0]    d2_next;
    logic                     stall_next;

    assign b_ready  = !b_reg.valid || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign meas_clip  = (a_measured_reg > SpeedClip) ? SpeedClip : a_measured_reg;
    assign stall_next = (meas_clip <= StallLevel);
    assign e0_next    = ErrW'(a_target_reg) - ErrW'(meas_clip);

    assign e0_x    = D2W'(e0_next);
    assign h0_x    = D2W'(hist0_reg);
    assign h1_x    = D2W'(hist1_reg);
    assign d1_next = D1W'(e0_x - h0_x);
    // second difference e0 - 2*e1 + e2
    assign d2_next = e0_x - (h0_x <<< 1) + h1_x;

    assign out_stage = b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_target_reg   <= target_speed;
            a_measured_reg <= measured_speed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg.valid <= 1'b0;
            hist0_reg   <= '0;
            hist1_reg   <= '0;
        end else if (b_ready) begin
            b_reg.valid <= a_valid_reg;
            if (a_valid_reg) begin
                hist1_reg <= hist0_reg;
                hist0_reg <= e0_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            b_reg.stall <= stall_next;
            b_reg.e0    <= e0_next;
            b_reg.d1    <= d1_next;
            b_reg.d2    <= d2_next;
        end
    end

endmodule

// ===== design/ipid_mul.sv =====
// gain products for the proportional, integral and derivative terms
// depends on ipid_pkg
module ipid_mul
    import ipid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  err_stage_t  in_stage,
    output logic        in_ready,
    input  gains_t      gains,
    output prod_stage_t out_stage,
    input  logic        out_ready
);

    prod_stage_t             prod_reg;
    logic signed [ProdW-1:0] kp_x;
    logic signed [ProdW-1:0] ki_x;
    logic signed [ProdW-1:0] kd_x;
    logic signed [ProdW-1:0] p_prop_next;
    logic signed [ProdW-1:0] p_integ_next;
    logic signed [ProdW-1:0] p_deriv_next;

    assign in_ready  = !prod_reg.valid || out_ready;
    assign out_stage = prod_reg;

    // gains are unsigned, zero-extend before the signed multiply
    assign kp_x = ProdW'($signed({1'b0, gains.prop}));
    assign ki_x = ProdW'($signed({1'b0, gains.integ}));
    assign kd_x = ProdW'($signed({1'b0, gains.deriv}));

    assign p_prop_next  = kp_x * ProdW'(in_stage.d1);
    assign p_integ_next = ki_x * ProdW'(in_stage.e0);
    assign p_deriv_next = kd_x * ProdW'(in_stage.d2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_reg.valid <= 1'b0;
        end else if (in_ready) begin
            prod_reg.valid <= in_stage.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_stage.valid) begin
            prod_reg.stall   <= in_stage.stall;
            prod_reg.p_prop  <= p_prop_next;
            prod_reg.p_integ <= p_integ_next;
            prod_reg.p_deriv <= p_deriv_next;
        end
    end

endmodule

// ===== design/ipid_acc.sv =====
// drive accumulator with stall stop, cap and bottom saturation; result register
// depends on ipid_pkg
module ipid_acc
    import ipid_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  prod_stage_t            in_stage,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [DutyW-1:0]       forward_duty,
    output logic signed [AccW-1:0] drive_level
);

    logic                   out_valid_reg;
    logic signed [AccW-1:0] acc_reg;
    logic signed [AccW-1:0] drive_reg;
    logic [DutyW-1:0]       duty_reg;

    logic signed [SumW-1:0] sum;
    logic signed [AccW-1:0] level_next;
    logic [DutyW-1:0]       duty_next;

    assign in_ready = !out_valid_reg || out_ready;

    assign sum = SumW'(in_stage.p_prop) + SumW'(in_stage.p_integ)
               + SumW'(in_stage.p_deriv) + SumW'(acc_reg);

    always_comb begin
        if (in_stage.stall) begin
            level_next = '0;
        end else if (sum > SumW'(DriveCap)) begin
            level_next = DriveCap;
        end else if (sum < SumW'(AccMin)) begin
            level_next = AccMin;
        end else begin
            level_next = sum[AccW-1:0];
        end
    end

    assign duty_next = level_next[AccW-1] ? '0 : level_next[DutyW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end else if (in_ready) begin
            out_valid_reg <= in_stage.valid;
            if (in_stage.valid) begin
                acc_reg <= level_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_stage.valid) begin
            drive_reg <= level_next;
            duty_reg  <= duty_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive_level  = drive_reg;
    assign forward_duty = duty_reg;

    a_cap_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (drive_reg <= DriveCap))
        else $error("drive level above cap");

    a_duty_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && drive_reg[AccW-1]) |-> (duty_reg == '0))
        else $error("duty nonzero for negative drive");

    a_duty_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !drive_reg[AccW-1]) |-> (duty_reg == drive_reg[DutyW-1:0]))
        else $error("duty differs from drive level");

    a_acc_track: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (acc_reg == drive_reg))
        else $error("accumulator out of step with shown result");

    a_stall_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_ready && in_stage.valid && in_stage.stall) |=> (drive_reg == '0))
        else $error("stall item did not clear drive");

endmodule

// ===== design/incremental_pid_motor_drive_unit.sv =====
// incremental pid speed controller for a motor drive, top level
// channels on s_/m_ stream ports, gains on an apb-style port
// depends on ipid_pkg, ipid_cfg, ipid_err, ipid_mul, ipid_acc
//
// each item on s_ carries a target and a measured speed; each gives one
// item on m_ with the forward pwm duty and the signed drive level.
// the measured speed is clipped to 250, the error history shifts, and
// kp*(e0-e1) + ki*e0 + kd*(e0-2e1+e2) is added to the drive accumulator;
// measured 15 or less clears it, it is capped at 3500 and floored at the
// most negative 32-bit value.
// pipeline: input register, error stage, multiply stage (three parallel
// 17x19, 17x18 and 17x20 multipliers), accumulate stage into the result register.
// an accepted item passes the error, product and result registers in turn to
// m_tvalid; one item per cycle is taken unless m_tready low stalls the stages.
// each stage holds its item while the next is full, so s_tready drops only
// once all four stages are occupied and m_tready stays low.
// reset clears gains, error history, accumulator and all valid flags.
// the user must write gains only while the block holds no item; the block does not enforce it.
module incremental_pid_motor_drive_unit
    import ipid_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // target_speed[15:0], measured_speed[31:16]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,   // forward_duty[11:0], drive_level[43:12], zero pad
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [CfgDataW-1:0] pwdata,
    output logic [CfgDataW-1:0] prdata,
    output logic                pready
);

    gains_t                 gains;
    err_stage_t             err_stage;
    prod_stage_t            prod_stage;
    logic                   err_ready;
    logic                   prod_ready;
    logic [DutyW-1:0]       forward_duty;
    logic signed [AccW-1:0] drive_level;

    ipid_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gains   (gains)
    );

    ipid_err u_err (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .target_speed   ($signed(s_tdata[15:0])),
        .measured_speed ($signed(s_tdata[31:16])),
        .out_stage      (err_stage),
        .out_ready      (err_ready)
    );

    ipid_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_stage  (err_stage),
        .in_ready  (err_ready),
        .gains     (gains),
        .out_stage (prod_stage),
        .out_ready (prod_ready)
    );

    ipid_acc u_acc (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_stage     (prod_stage),
        .in_ready     (prod_ready),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .forward_duty (forward_duty),
        .drive_level  (drive_level)
    );

    assign m_tdata = {4'b0000, drive_level, forward_duty};

endmodule
